FILE: hdl/toy_isa_execute_unit_defines.svh
// Assertion macros shared by the execute unit sources.
// Define ASSERT_OFF to compile every check away.
`ifndef TOY_ISA_EXECUTE_UNIT_DEFINES_SVH
`define TOY_ISA_EXECUTE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TIEX_ASSERT(lbl, clk_s, rst_s, prop_e, msg_s) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop_e)) else $error(msg_s);
`define TIEX_NEVER(lbl, clk_s, rst_s, cond_e, msg_s) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond_e)) else $error(msg_s);
`else
`define TIEX_ASSERT(lbl, clk_s, rst_s, prop_e, msg_s)
`define TIEX_NEVER(lbl, clk_s, rst_s, cond_e, msg_s)
`endif
`endif

FILE: hdl/tiex_pkg.sv
package tiex_pkg;

    localparam int NUM_REGS   = 13;
    localparam int REG_ADDR_W = $clog2(NUM_REGS);
    localparam int WORD_W     = 32;
    localparam int ADD_W      = WORD_W + 2;
    localparam int LOOP_CNT_W = $clog2(WORD_W);

    localparam logic [LOOP_CNT_W-1:0] LAST_STEP = LOOP_CNT_W'(WORD_W - 1);

    // Opcodes: bits 31:8 of the word, move-immediate bits 31:16, halt is the whole word
    localparam logic [23:0] OPC_CMP   = 24'h000100;
    localparam logic [23:0] OPC_ADD   = 24'h000101;
    localparam logic [23:0] OPC_SUB   = 24'h000102;
    localparam logic [23:0] OPC_MUL   = 24'h000103;
    localparam logic [23:0] OPC_DIV   = 24'h000104;
    localparam logic [23:0] OPC_MOVE2 = 24'h000105;
    localparam logic [23:0] OPC_JUMP  = 24'h000106;
    localparam logic [23:0] OPC_JEQ   = 24'h000107;
    localparam logic [31:0] OPC_HLT   = 32'h0001_0800;
    localparam logic [15:0] OPC_MOVE1 = 16'h0000;

    localparam logic [31:0] PC_RESET = 32'hFFFF_FFFC;
    localparam logic [31:0] PC_STEP  = 32'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_REG  = 2'd1;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd3;

    // Arithmetic unit operations; codes follow the low opcode bits
    localparam logic [2:0] AOP_CMP = 3'd0;
    localparam logic [2:0] AOP_ADD = 3'd1;
    localparam logic [2:0] AOP_SUB = 3'd2;
    localparam logic [2:0] AOP_MUL = 3'd3;
    localparam logic [2:0] AOP_DIV = 3'd4;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } arith_ctl_t;

    typedef struct packed {
        logic done;
        logic zero;
        logic neg;
    } arith_sts_t;

endpackage

FILE: hdl/tiex_ram.sv
module tiex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/tiex_arith.sv
`include "toy_isa_execute_unit_defines.svh"

module tiex_arith (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tiex_pkg::arith_ctl_t          ctl,
    input  logic [tiex_pkg::WORD_W-1:0]   opnd_a,
    input  logic [tiex_pkg::WORD_W-1:0]   opnd_b,
    output tiex_pkg::arith_sts_t          sts,
    output logic [tiex_pkg::WORD_W-1:0]   result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ONE  = 3'd1;
    localparam logic [2:0] S_ABSN = 3'd2;
    localparam logic [2:0] S_ABSD = 3'd3;
    localparam logic [2:0] S_LOOP = 3'd4;
    localparam logic [2:0] S_FIX  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int W  = tiex_pkg::WORD_W;
    localparam int AW = tiex_pkg::ADD_W;

    logic [2:0]                        state_reg, state_next;
    logic [2:0]                        op_reg, op_next;
    logic [W-1:0]                      opd_reg, opd_next;
    logic [W-1:0]                      q_reg, q_next;
    logic [W-1:0]                      acc_reg, acc_next;
    logic [W-1:0]                      res_reg, res_next;
    logic [tiex_pkg::LOOP_CNT_W-1:0]   count_reg, count_next;
    logic                              sgn_reg, sgn_next;
    logic                              zero_reg, zero_next;
    logic                              neg_reg, neg_next;

    logic [AW-1:0] add_x;
    logic [AW-1:0] add_y;
    logic          add_sub;
    logic [AW-1:0] add_sum;

    // The one adder that every operation shares
    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{(AW-1){1'b0}}, add_sub};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        opd_next   = opd_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        count_next = count_reg;
        sgn_next   = sgn_reg;
        zero_next  = zero_reg;
        neg_next   = neg_reg;
        add_x      = '0;
        add_y      = '0;
        add_sub    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next    = ctl.op;
                    opd_next   = opnd_a;
                    q_next     = opnd_b;
                    acc_next   = '0;
                    count_next = '0;
                    sgn_next   = opnd_a[W-1] ^ opnd_b[W-1];
                    priority if (ctl.op == tiex_pkg::AOP_MUL)
                    begin
                        state_next = S_LOOP;
                    end
                    else if (ctl.op == tiex_pkg::AOP_DIV)
                    begin
                        state_next = S_ABSN;
                    end
                    else
                    begin
                        state_next = S_ONE;
                    end
                end
            end
            S_ONE:
            begin
                // b + a or b - a, exact in the wide adder
                add_x      = {{2{q_reg[W-1]}}, q_reg};
                add_y      = {{2{opd_reg[W-1]}}, opd_reg};
                add_sub    = (op_reg != tiex_pkg::AOP_ADD);
                res_next   = add_sum[W-1:0];
                zero_next  = (add_sum == '0);
                neg_next   = add_sum[AW-1];
                state_next = S_DONE;
            end
            S_ABSN:
            begin
                add_y   = {2'b00, q_reg};
                add_sub = 1'b1;
                if (q_reg[W-1])
                begin
                    q_next = add_sum[W-1:0];
                end
                state_next = S_ABSD;
            end
            S_ABSD:
            begin
                add_y   = {2'b00, opd_reg};
                add_sub = 1'b1;
                if (opd_reg[W-1])
                begin
                    opd_next = add_sum[W-1:0];
                end
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (op_reg == tiex_pkg::AOP_MUL)
                begin
                    // shift-add, low word of the product only
                    add_x = {2'b00, acc_reg};
                    add_y = {2'b00, opd_reg};
                    if (q_reg[0])
                    begin
                        acc_next = add_sum[W-1:0];
                    end
                    opd_next = {opd_reg[W-2:0], 1'b0};
                    q_next   = {1'b0, q_reg[W-1:1]};
                end
                else
                begin
                    // restoring division on magnitudes
                    add_x   = {1'b0, acc_reg, q_reg[W-1]};
                    add_y   = {2'b00, opd_reg};
                    add_sub = 1'b1;
                    if (!add_sum[AW-1])
                    begin
                        acc_next = add_sum[W-1:0];
                    end
                    else
                    begin
                        acc_next = {acc_reg[W-2:0], q_reg[W-1]};
                    end
                    q_next = {q_reg[W-2:0], ~add_sum[AW-1]};
                end
                count_next = count_reg + 1'b1;
                if (count_reg == tiex_pkg::LAST_STEP)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                // pass the product, or sign-correct the quotient
                if (op_reg == tiex_pkg::AOP_DIV)
                begin
                    add_y   = {2'b00, q_reg};
                    add_sub = sgn_reg;
                end
                else
                begin
                    add_y = {2'b00, acc_reg};
                end
                res_next   = add_sum[W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        opd_reg  <= opd_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        sgn_reg  <= sgn_next;
        zero_reg <= zero_next;
        neg_reg  <= neg_next;
    end

    assign sts.done = (state_reg == S_DONE);
    assign sts.zero = zero_reg;
    assign sts.neg  = neg_reg;
    assign result   = res_reg;

    `TIEX_ASSERT(a_done_pulse, clk, rst_n, sts.done |=> !sts.done, "done held over two cycles")
    `TIEX_ASSERT(a_start_idle, clk, rst_n, ctl.start |-> (state_reg == S_IDLE), "start while busy")
    `TIEX_ASSERT(a_mul_enter, clk, rst_n, (state_reg == S_IDLE) && ctl.start && (ctl.op == tiex_pkg::AOP_MUL) |=> (state_reg == S_LOOP) && (count_reg == '0), "multiply did not enter loop")

endmodule

FILE: hdl/toy_isa_execute_unit.sv
// Move-immediate, jumps, halt, unknown words and bad register indexes finish in DECODE;
// register move and divide by zero finish in RDB; the rest wait for the arithmetic unit.
// One item at a time; the next item is taken in the cycle after the result is
// loaded, so the 32-step loop of the shared add/subtract unit sets the slow cases.
// Reset (rst_n low, asynchronous): registers read as zero, flags and halt clear,
// PC at -4, no result pending.
`include "toy_isa_execute_unit_defines.svh"

module toy_isa_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               instr_valid,
    output logic               instr_ready,
    input  logic [31:0]        instr_word,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] prog_counter,
    output logic               wrote_reg,
    output logic [3:0]         dest_index,
    output logic signed [31:0] dest_value,
    output logic               zero_flag,
    output logic               neg_flag,
    output logic               halted,
    output logic [1:0]         error_code
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;   // wait for an item
    localparam logic [2:0] ST_DECODE = 3'd1;   // decode, finish simple ops, read A
    localparam logic [2:0] ST_RDA    = 3'd2;   // capture A, read B
    localparam logic [2:0] ST_RDB    = 3'd3;   // capture B, start the unit
    localparam logic [2:0] ST_WAIT   = 3'd4;   // wait for the arithmetic unit
    localparam logic [2:0] ST_OUT    = 3'd5;   // load the output register

    localparam int NR = tiex_pkg::NUM_REGS;
    localparam int RA = tiex_pkg::REG_ADDR_W;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   instr_reg, instr_next;
    logic [31:0]   pc_reg, pc_next;
    logic          zero_reg, zero_next;
    logic          neg_reg, neg_next;
    logic          halt_reg, halt_next;
    logic [NR-1:0] rf_valid_reg, rf_valid_next;
    logic [31:0]   a_reg, a_next;

    // Result of the item in flight
    logic          res_wrote_reg, res_wrote_next;
    logic [3:0]    res_idx_reg, res_idx_next;
    logic [31:0]   res_val_reg, res_val_next;
    logic [1:0]    res_err_reg, res_err_next;

    // Output register
    logic          result_valid_reg, result_valid_next;
    logic [31:0]   out_pc_reg, out_pc_next;
    logic          out_wrote_reg, out_wrote_next;
    logic [3:0]    out_idx_reg, out_idx_next;
    logic [31:0]   out_val_reg, out_val_next;
    logic          out_zero_reg, out_zero_next;
    logic          out_neg_reg, out_neg_next;
    logic          out_halt_reg, out_halt_next;
    logic [1:0]    out_err_reg, out_err_next;

    // Decode of the held word
    logic [3:0]    ra;
    logic [3:0]    rb;
    logic [23:0]   op24;
    logic          is_move1;
    logic          is_hlt;
    logic          is_jump;
    logic          is_jeq;
    logic          is_alu;
    logic          ra_ok;
    logic          rb_ok;
    logic [31:0]   pc_plus4;
    logic [31:0]   label_pc;

    // Register file access
    logic          rf_we;
    logic [3:0]    rf_widx;
    logic [31:0]   rf_wdata;
    logic [RA-1:0] rf_raddr;
    logic [RA-1:0] rf_vaddr;
    logic [31:0]   ram_rdata;
    logic [31:0]   rf_rd_val;

    tiex_pkg::arith_ctl_t arith_ctl;
    tiex_pkg::arith_sts_t arith_sts;
    logic [31:0]          arith_result;

    assign ra       = instr_reg[7:4];
    assign rb       = instr_reg[3:0];
    assign op24     = instr_reg[31:8];
    assign is_move1 = (instr_reg[31:16] == tiex_pkg::OPC_MOVE1);
    assign is_hlt   = (instr_reg == tiex_pkg::OPC_HLT);
    assign is_jump  = (op24 == tiex_pkg::OPC_JUMP);
    assign is_jeq   = (op24 == tiex_pkg::OPC_JEQ);
    assign is_alu   = (op24 >= tiex_pkg::OPC_CMP) && (op24 <= tiex_pkg::OPC_MOVE2);
    assign ra_ok    = (5'(ra) < 5'(NR));
    assign rb_ok    = (5'(rb) < 5'(NR));
    assign pc_plus4 = pc_reg + tiex_pkg::PC_STEP;
    assign label_pc = {24'd0, instr_reg[7:0]};

    // A is read from DECODE, B from RDA; the valid bit follows the captured address
    assign rf_raddr  = (state_reg == ST_DECODE) ? ra[RA-1:0] : rb[RA-1:0];
    assign rf_vaddr  = (state_reg == ST_RDA) ? ra[RA-1:0] : rb[RA-1:0];
    assign rf_rd_val = rf_valid_reg[rf_vaddr] ? ram_rdata : 32'd0;

    tiex_ram #(
        .WIDTH (32),
        .DEPTH (NR)
    ) u_regfile (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_widx[RA-1:0]),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (ram_rdata)
    );

    tiex_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (arith_ctl),
        .opnd_a (a_reg),
        .opnd_b (rf_rd_val),
        .sts    (arith_sts),
        .result (arith_result)
    );

    always_comb
    begin
        state_next        = state_reg;
        instr_next        = instr_reg;
        pc_next           = pc_reg;
        zero_next         = zero_reg;
        neg_next          = neg_reg;
        halt_next         = halt_reg;
        rf_valid_next     = rf_valid_reg;
        a_next            = a_reg;
        res_wrote_next    = res_wrote_reg;
        res_idx_next      = res_idx_reg;
        res_val_next      = res_val_reg;
        res_err_next      = res_err_reg;
        result_valid_next = result_valid_reg;
        out_pc_next       = out_pc_reg;
        out_wrote_next    = out_wrote_reg;
        out_idx_next      = out_idx_reg;
        out_val_next      = out_val_reg;
        out_zero_next     = out_zero_reg;
        out_neg_next      = out_neg_reg;
        out_halt_next     = out_halt_reg;
        out_err_next      = out_err_reg;
        rf_we             = 1'b0;
        rf_widx           = rb;
        rf_wdata          = 32'd0;
        arith_ctl.start   = 1'b0;
        // unit op codes match the low opcode bits
        arith_ctl.op      = op24[2:0];

        // Drop the pending result once the consumer takes it
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (instr_valid)
                begin
                    instr_next = instr_word;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                res_wrote_next = 1'b0;
                res_idx_next   = 4'd0;
                res_val_next   = 32'd0;
                res_err_next   = tiex_pkg::ERR_NONE;
                state_next     = ST_OUT;
                priority if (halt_reg)
                begin
                    // frozen: report state, change nothing
                end
                else if (is_move1)
                begin
                    if (rb_ok)
                    begin
                        rf_we          = 1'b1;
                        rf_wdata       = {20'd0, instr_reg[15:4]};
                        res_wrote_next = 1'b1;
                        res_idx_next   = rb;
                        res_val_next   = rf_wdata;
                    end
                    else
                    begin
                        res_err_next = tiex_pkg::ERR_BAD_REG;
                    end
                    pc_next = pc_plus4;
                end
                else if (is_hlt)
                begin
                    halt_next = 1'b1;
                end
                else if (is_jump)
                begin
                    pc_next = label_pc;
                end
                else if (is_jeq)
                begin
                    if (zero_reg)
                    begin
                        pc_next = label_pc;
                    end
                end
                else if (is_alu)
                begin
                    if (ra_ok && rb_ok)
                    begin
                        state_next = ST_RDA;
                    end
                    else
                    begin
                        res_err_next = tiex_pkg::ERR_BAD_REG;
                        pc_next      = pc_plus4;
                    end
                end
                else
                begin
                    res_err_next = tiex_pkg::ERR_UNKNOWN;
                end
            end
            ST_RDA:
            begin
                a_next     = rf_rd_val;
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                pc_next = pc_plus4;
                priority if (op24 == tiex_pkg::OPC_MOVE2)
                begin
                    rf_we          = 1'b1;
                    rf_wdata       = a_reg;
                    res_wrote_next = 1'b1;
                    res_idx_next   = rb;
                    res_val_next   = a_reg;
                    state_next     = ST_OUT;
                end
                else if ((op24 == tiex_pkg::OPC_DIV) && (a_reg == 32'd0))
                begin
                    res_err_next = tiex_pkg::ERR_DIV_ZERO;
                    state_next   = ST_OUT;
                end
                else
                begin
                    arith_ctl.start = 1'b1;
                    state_next      = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (arith_sts.done)
                begin
                    if (op24 == tiex_pkg::OPC_CMP)
                    begin
                        zero_next = arith_sts.zero;
                        neg_next  = arith_sts.neg;
                    end
                    else
                    begin
                        rf_we          = 1'b1;
                        rf_wdata       = arith_result;
                        res_wrote_next = 1'b1;
                        res_idx_next   = rb;
                        res_val_next   = arith_result;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    out_pc_next       = pc_reg;
                    out_wrote_next    = res_wrote_reg;
                    out_idx_next      = res_idx_reg;
                    out_val_next      = res_val_reg;
                    out_zero_next     = zero_reg;
                    out_neg_next      = neg_reg;
                    out_halt_next     = halt_reg;
                    out_err_next      = res_err_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Mark written entries; unwritten ones read as zero
        if (rf_we)
        begin
            rf_valid_next[rf_widx[RA-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pc_reg           <= tiex_pkg::PC_RESET;
            zero_reg         <= 1'b0;
            neg_reg          <= 1'b0;
            halt_reg         <= 1'b0;
            rf_valid_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pc_reg           <= pc_next;
            zero_reg         <= zero_next;
            neg_reg          <= neg_next;
            halt_reg         <= halt_next;
            rf_valid_reg     <= rf_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg     <= instr_next;
        a_reg         <= a_next;
        res_wrote_reg <= res_wrote_next;
        res_idx_reg   <= res_idx_next;
        res_val_reg   <= res_val_next;
        res_err_reg   <= res_err_next;
        out_pc_reg    <= out_pc_next;
        out_wrote_reg <= out_wrote_next;
        out_idx_reg   <= out_idx_next;
        out_val_reg   <= out_val_next;
        out_zero_reg  <= out_zero_next;
        out_neg_reg   <= out_neg_next;
        out_halt_reg  <= out_halt_next;
        out_err_reg   <= out_err_next;
    end

    assign instr_ready  = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign prog_counter = $signed(out_pc_reg);
    assign wrote_reg    = out_wrote_reg;
    assign dest_index   = out_idx_reg;
    assign dest_value   = $signed(out_val_reg);
    assign zero_flag    = out_zero_reg;
    assign neg_flag     = out_neg_reg;
    assign halted       = out_halt_reg;
    assign error_code   = out_err_reg;

    `TIEX_ASSERT(a_halt_sticky, clk, rst_n, halt_reg |=> halt_reg, "halt mark cleared")
    `TIEX_NEVER(a_no_write_halted, clk, rst_n, halt_reg && rf_we, "register write after halt")
    `TIEX_ASSERT(a_write_in_range, clk, rst_n, rf_we |-> (5'(rf_widx) < 5'(NR)), "write to missing register")

endmodule

FILE: test/toy_isa_execute_unit_tb.sv
`timescale 1ns / 1ps

module toy_isa_execute_unit_tb;

    // Random instructions per idle phase, and the number of handshake-free
    // cycles after which the run is declared hung.
    localparam int RAND_PER_PHASE = 650;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 60;

    // Outcome of the most recent compare, as the unit remembers it for JEQ
    typedef enum logic [1:0] {
        CMP_NONE = 2'd0,
        CMP_EQ   = 2'd1,
        CMP_GT   = 2'd2,
        CMP_LT   = 2'd3
    } cmp_state_t;

    // Everything the unit reports for one instruction
    typedef struct packed {
        logic [31:0] pc;
        logic        wrote;
        logic [3:0]  idx;
        logic [31:0] data;
        logic        zero;
        logic        neg;
        logic        halt;
        logic [1:0]  err;
    } exec_result_t;

    // One row of the directed program: typed rows carry a hand-written result
    typedef struct {
        logic [31:0]  word;
        bit           typed;
        exec_result_t want;
    } prog_row_t;

    logic               clk;
    logic               rst_n;
    logic               instr_valid;
    logic               instr_ready;
    logic [31:0]        instr_word;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic signed [31:0] prog_counter;
    logic               wrote_reg;
    logic [3:0]         dest_index;
    logic signed [31:0] dest_value;
    logic               zero_flag;
    logic               neg_flag;
    logic               halted;
    logic [1:0]         error_code;

    // Architectural state tracked alongside the unit
    logic [31:0] arch_regs [tiex_pkg::NUM_REGS];
    logic [31:0] arch_pc;
    cmp_state_t  arch_cmp;
    logic        arch_zero;
    logic        arch_neg;
    logic        arch_halted;

    exec_result_t pending_results [$];
    exec_result_t exec_want;
    prog_row_t    directed_prog [$];

    int snd_idle_pct;
    int rcv_idle_pct;
    int idle_cycles  = 0;
    int mismatch_cnt = 0;
    int instrs_sent;
    int results_seen = 0;
    int writes_seen  = 0;
    int errors_seen  = 0;

    toy_isa_execute_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .instr_word   (instr_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .prog_counter (prog_counter),
        .wrote_reg    (wrote_reg),
        .dest_index   (dest_index),
        .dest_value   (dest_value),
        .zero_flag    (zero_flag),
        .neg_flag     (neg_flag),
        .halted       (halted),
        .error_code   (error_code)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Execute one instruction on the tracked state and return what the unit
    // must report for it.
    function automatic exec_result_t execute_instr(input logic [31:0] w);
        exec_result_t     r;
        logic [3:0]       ra;
        logic [3:0]       rb;
        logic [23:0]      op;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      mag_n;
        logic [31:0]      mag_d;
        logic [31:0]      quot;
        logic signed [32:0] diff;
        r  = '0;
        ra = w[7:4];
        rb = w[3:0];
        op = w[31:8];
        // Once halted, every word is dropped and the frozen state is shown
        if (!arch_halted)
        begin
            if (w[31:16] == tiex_pkg::OPC_MOVE1)
            begin
                if (rb >= tiex_pkg::NUM_REGS)
                    r.err = tiex_pkg::ERR_BAD_REG;
                else
                begin
                    r.wrote = 1'b1;
                    r.data  = {20'h0, w[15:4]};
                end
                arch_pc = arch_pc + tiex_pkg::PC_STEP;
            end
            else if (w == tiex_pkg::OPC_HLT)
                arch_halted = 1'b1;
            else if (op == tiex_pkg::OPC_JUMP)
                arch_pc = {24'h0, w[7:0]};
            else if (op == tiex_pkg::OPC_JEQ)
            begin
                // Not taken leaves the PC where it is, no step of four
                if (arch_cmp == CMP_EQ)
                    arch_pc = {24'h0, w[7:0]};
            end
            else if (op >= tiex_pkg::OPC_CMP && op <= tiex_pkg::OPC_MOVE2)
            begin
                if (ra >= tiex_pkg::NUM_REGS || rb >= tiex_pkg::NUM_REGS)
                    r.err = tiex_pkg::ERR_BAD_REG;
                else
                begin
                    a = arch_regs[ra];
                    b = arch_regs[rb];
                    case (op)
                        tiex_pkg::OPC_CMP:
                        begin
                            // Compare on the exact difference, no wrap
                            diff = $signed({b[31], b}) - $signed({a[31], a});
                            arch_zero = (diff == 0);
                            arch_neg  = (diff < 0);
                            if (diff == 0)
                                arch_cmp = CMP_EQ;
                            else if (diff > 0)
                                arch_cmp = CMP_GT;
                            else
                                arch_cmp = CMP_LT;
                        end
                        tiex_pkg::OPC_ADD:
                        begin
                            r.wrote = 1'b1;
                            r.data  = a + b;
                        end
                        tiex_pkg::OPC_SUB:
                        begin
                            r.wrote = 1'b1;
                            r.data  = b - a;
                        end
                        tiex_pkg::OPC_MUL:
                        begin
                            r.wrote = 1'b1;
                            r.data  = a * b;
                        end
                        tiex_pkg::OPC_DIV:
                        begin
                            if (a == 32'd0)
                                r.err = tiex_pkg::ERR_DIV_ZERO;
                            else
                            begin
                                // Divide magnitudes, then fix the sign: truncates
                                // toward zero and wraps min / -1 to min
                                mag_n   = b[31] ? -b : b;
                                mag_d   = a[31] ? -a : a;
                                quot    = mag_n / mag_d;
                                r.wrote = 1'b1;
                                r.data  = (a[31] ^ b[31]) ? -quot : quot;
                            end
                        end
                        default:
                        begin
                            r.wrote = 1'b1;
                            r.data  = a;
                        end
                    endcase
                end
                arch_pc = arch_pc + tiex_pkg::PC_STEP;
            end
            else
                r.err = tiex_pkg::ERR_UNKNOWN;
            if (r.wrote)
            begin
                r.idx         = rb;
                arch_regs[rb] = r.data;
            end
        end
        r.pc   = arch_pc;
        r.zero = arch_zero;
        r.neg  = arch_neg;
        r.halt = arch_halted;
        return r;
    endfunction

    // Mostly valid indexes, now and then one past the register file (13 to 15)
    function automatic logic [3:0] pick_reg();
        if ($urandom_range(9) == 0)
            return 4'($urandom_range(15, tiex_pkg::NUM_REGS));
        return 4'($urandom_range(tiex_pkg::NUM_REGS - 1));
    endfunction

    // Mostly well-formed instructions with random operands, some noise words.
    // Halt is kept out: it would freeze the rest of the run.
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 25)
            w = {tiex_pkg::OPC_MOVE1, 12'($urandom), pick_reg()};
        else if (sel < 85)
            w = {tiex_pkg::OPC_CMP + 24'($urandom_range(7)), pick_reg(), pick_reg()};
        else if (sel < 93)
            w = {tiex_pkg::OPC_CMP[23:8], 16'($urandom)};
        else
            w = $urandom;
        if (w == tiex_pkg::OPC_HLT)
            w = tiex_pkg::OPC_HLT + 32'd1;
        return w;
    endfunction

    task automatic row(input logic [31:0] w);
        directed_prog.push_back('{w, 1'b0, exec_result_t'('0)});
    endtask

    // Hand-written result; flags and halt are still clear in these rows
    task automatic row_typed(input logic [31:0] w, input logic [31:0] pc, input logic wr,
                             input logic [3:0] idx, input logic [31:0] data,
                             input logic [1:0] err);
        exec_result_t e;
        e       = '0;
        e.pc    = pc;
        e.wrote = wr;
        e.idx   = idx;
        e.data  = data;
        e.err   = err;
        directed_prog.push_back('{w, 1'b1, e});
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h, expected %h",
                 results_seen, what, got, want);
        mismatch_cnt++;
    endtask

    // Present one item, hold it until accepted, then log its expected result.
    // Valid stays high on return so a back-to-back item needs no toggle.
    task automatic send_instr(input logic [31:0] w, input bit typed,
                              input exec_result_t typed_want);
        exec_result_t r;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
        end
        instr_valid <= 1'b1;
        instr_word  <= w;
        @(posedge clk);
        while (!instr_ready)
            @(posedge clk);
        instrs_sent++;
        // Advance the tracked state on every item, typed rows included
        r = execute_instr(w);
        pending_results.push_back(typed ? typed_want : r);
    endtask

    // Check each result against the oldest pending one, then redraw ready
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, pc", prog_counter, 32'h0);
            else
            begin
                exec_want = pending_results.pop_front();
                if (prog_counter !== exec_want.pc)
                    report_mismatch("prog_counter", prog_counter, exec_want.pc);
                if (wrote_reg !== exec_want.wrote)
                    report_mismatch("wrote_reg", 32'(wrote_reg), 32'(exec_want.wrote));
                if (dest_index !== exec_want.idx)
                    report_mismatch("dest_index", 32'(dest_index), 32'(exec_want.idx));
                if (dest_value !== exec_want.data)
                    report_mismatch("dest_value", dest_value, exec_want.data);
                if (zero_flag !== exec_want.zero)
                    report_mismatch("zero_flag", 32'(zero_flag), 32'(exec_want.zero));
                if (neg_flag !== exec_want.neg)
                    report_mismatch("neg_flag", 32'(neg_flag), 32'(exec_want.neg));
                if (halted !== exec_want.halt)
                    report_mismatch("halted", 32'(halted), 32'(exec_want.halt));
                if (error_code !== exec_want.err)
                    report_mismatch("error_code", 32'(error_code), 32'(exec_want.err));
                if (exec_want.wrote)
                    writes_seen++;
                if (exec_want.err != tiex_pkg::ERR_NONE)
                    errors_seen++;
            end
            results_seen++;
        end
        result_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((instr_valid && instr_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        instr_valid  = 1'b0;
        instr_word   = 32'h0;
        instrs_sent  = 0;
        // First phase: sender idles rarely, receiver stalls most of the time
        snd_idle_pct = 13;
        rcv_idle_pct = 88;

        foreach (arch_regs[i])
            arch_regs[i] = 32'h0;
        arch_pc     = tiex_pkg::PC_RESET;
        arch_cmp    = CMP_NONE;
        arch_zero   = 1'b0;
        arch_neg    = 1'b0;
        arch_halted = 1'b0;

        // Directed program. Register contents noted as they build up.
        row_typed(32'h0000_FFF0, 32'd0,  1'b1, 4'd0,  32'd4095,
                  tiex_pkg::ERR_NONE);                                  // r0 = max imm
        row_typed(32'h0000_000C, 32'd4,  1'b1, 4'd12, 32'd0,
                  tiex_pkg::ERR_NONE);                                  // r12 = 0, top reg
        row_typed(32'h0000_123D, 32'd8,  1'b0, 4'd0,  32'd0,
                  tiex_pkg::ERR_BAD_REG);                               // first bad index
        row_typed(32'h0000_FFFF, 32'd12, 1'b0, 4'd0,  32'd0,
                  tiex_pkg::ERR_BAD_REG);                               // last bad index
        row_typed(32'h0000_0011, 32'd16, 1'b1, 4'd1,  32'd1,
                  tiex_pkg::ERR_NONE);                                  // r1 = 1
        row(32'h0001_0212);                                    // r2 = 0 - 1 = -1
        row(32'h0000_8003);                                    // r3 = 2048
        row(32'h0000_8004);                                    // r4 = 2048
        row(32'h0001_0334);                                    // r4 = 2^22
        row(32'h0000_2005);                                    // r5 = 512
        row_typed(32'h0001_0345, 32'd40, 1'b1, 4'd5, 32'h8000_0000,
                  tiex_pkg::ERR_NONE);                                  // r5 = min
        row_typed(32'h0001_0425, 32'd44, 1'b1, 4'd5, 32'h8000_0000,
                  tiex_pkg::ERR_NONE);                                  // min / -1
        row_typed(32'h0001_04C0, 32'd48, 1'b0, 4'd0, 32'd0,
                  tiex_pkg::ERR_DIV_ZERO);                              // r0 / r12
        row_typed(32'h0001_04D0, 32'd52, 1'b0, 4'd0, 32'd0,
                  tiex_pkg::ERR_BAD_REG);                               // bad divisor
        row(32'h0001_0015);                                    // cmp min against 1: less
        row(32'h0001_0780);                                    // jeq not taken
        row(32'h0001_0020);                                    // cmp 4095 against -1: greater
        row(32'h0001_0000);                                    // cmp r0 with itself: equal
        row(32'h0001_07FF);                                    // jeq taken to 0xff
        row(32'h0001_0155);                                    // min + min wraps to 0
        row(32'h0001_0506);                                    // r6 = r0
        row(32'h0001_0600);                                    // jump to 0
        row(32'hFFFF_FFFF);                                    // unknown, all ones
        row(32'h0001_0801);                                    // unknown, next to halt
        row(32'h0001_0900);                                    // unknown, past the jumps

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_prog[i])
            send_instr(directed_prog[i].word, directed_prog[i].typed, directed_prog[i].want);

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                snd_idle_pct = 88;
                rcv_idle_pct = 13;
            end
            else if (ph == 2)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            repeat (RAND_PER_PHASE)
                send_instr(rand_instr(), 1'b0, '0);
            // Hold off the sender until the unit has drained completely
            instr_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end

        // Halt last, then a few words that the frozen unit must drop
        send_instr(tiex_pkg::OPC_HLT, 1'b0, '0);
        repeat (4)
            send_instr(rand_instr(), 1'b0, '0);
        send_instr(32'h0000_0010, 1'b0, '0);
        instr_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d instructions (%0d directed, halt at the end), %0d results",
                 instrs_sent, directed_prog.size(), results_seen);
        $display("with %0d register writes and %0d error outcomes, %0d mismatches",
                 writes_seen, errors_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tiex_pkg.sv
hdl/tiex_ram.sv
hdl/tiex_arith.sv
hdl/toy_isa_execute_unit.sv
test/toy_isa_execute_unit_tb.sv
